// ===== sv/cfu_pkg.sv =====
// Shared types and constants for the clique field updater.
package cfu_pkg;

  localparam int EDGE_W   = 8;
  localparam int SUB_W    = 12;
  localparam int SLOT_W   = 7;
  localparam int MEMB_W   = 3;
  localparam int FIELD_W  = 16;
  localparam int COUNT_W  = 4;
  localparam int CLIQUE_EDGES = 6;

  typedef enum logic [2:0] {
    FN_LOAD_SOE = 3'd0,
    FN_LOAD_EOS = 3'd1,
    FN_INIT_EDGE = 3'd2,
    FN_INIT_COUNT = 3'd3,
    FN_FLIP = 3'd4,
    FN_READ = 3'd5
  } func_t;

  typedef struct packed {
    logic [2:0]                func;
    logic [EDGE_W-1:0]         edge_req;
    logic [SLOT_W-1:0]         slot;
    logic [SUB_W-1:0]          subgraph;
    logic signed [FIELD_W-1:0] field_value;
    logic                      color;
    logic [COUNT_W-1:0]        count;
  } req_t;

  typedef struct packed {
    logic                      read_color;
    logic signed [FIELD_W-1:0] read_field;
    logic                      done_res;
  } rsp_t;

endpackage

// ===== sv/cfu_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module cfu_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/clique_field_updater.sv =====
// Top level of the clique field updater: item sequencer and state memories.
//
// The block holds edge colours and 16-bit local fields, a 4-bit blue count per
// subgraph, and two incidence tables, all in single-port-read synchronous RAMs
// that hold nothing meaningful until loaded. Each request beat carries one item
// and yields exactly one response beat with the addressed edge's colour and
// field after the item. A flip visits all 128 subgraph slots of its edge through
// the incidence RAM, plus for a completed or destroyed clique an update of the
// flipped edge and of every member edge, and for a near-complete clique a scan
// of the members; every field update goes through the edge RAM, which serves
// one read a cycle. One item is in work at a time; a finished response may wait
// in the output register while the next request beat is taken.
module clique_field_updater
  import cfu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_F_RD  = 14'b00000000000010,
    ST_F_TGL = 14'b00000000000100,
    ST_SG_RD = 14'b00000000001000,
    ST_SG_D  = 14'b00000000010000,
    ST_BC_D  = 14'b00000000100000,
    ST_BE_RD = 14'b00000001000000,
    ST_BE_WR = 14'b00000010000000,
    ST_M_RD  = 14'b00000100000000,
    ST_M_D   = 14'b00001000000000,
    ST_M_WR  = 14'b00010000000000,
    ST_NXT   = 14'b00100000000000,
    ST_O_RD  = 14'b01000000000000,
    ST_O_WR  = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  // item registers
  logic [EDGE_W-1:0] e;
  logic              blue;
  logic [SLOT_W-1:0] i;
  logic [MEMB_W-1:0] j;
  logic [SUB_W-1:0]  s;
  logic              mode_all;
  logic              want_col;
  logic              skip_en;
  logic [EDGE_W-1:0] m;

  // RAM ports
  logic                        eg_we, eg_re;
  logic [EDGE_W-1:0]           eg_waddr, eg_raddr;
  logic [FIELD_W:0]            eg_wdata, eg_rdata;
  logic                        soe_we, soe_re;
  logic [EDGE_W+SLOT_W-1:0]    soe_waddr, soe_raddr;
  logic [SUB_W-1:0]            soe_rdata;
  logic                        eos_we, eos_re;
  logic [SUB_W+MEMB_W-1:0]     eos_waddr, eos_raddr;
  logic [EDGE_W-1:0]           eos_rdata;
  logic                        bc_we, bc_re;
  logic [SUB_W-1:0]            bc_waddr;
  logic [COUNT_W-1:0]          bc_wdata, bc_rdata;

  logic              acc;
  logic [COUNT_W-1:0] n;
  logic              act_all, act_first, f_col, f_skip;
  logic [FIELD_W-1:0] d_mem, d_e;
  logic              m_hit, last_j;

  assign req_ready = (state == ST_IDLE) && !rst;
  assign acc       = req_valid && req_ready;

  // member delta: down when the edge turned blue, up when it turned red
  assign d_mem  = blue ? {FIELD_W{1'b1}} : FIELD_W'(1);
  assign d_e    = blue ? FIELD_W'(1) : {FIELD_W{1'b1}};
  assign n      = blue ? bc_rdata + COUNT_W'(1) : bc_rdata - COUNT_W'(1);
  assign m_hit  = mode_all || (eg_rdata[FIELD_W] == want_col);
  assign last_j = (j == MEMB_W'(CLIQUE_EDGES - 1));

  // decide the subgraph's action from its new count
  always_comb begin
    act_all   = 1'b0;
    act_first = 1'b0;
    f_col     = 1'b0;
    f_skip    = 1'b0;
    if (blue) begin
      if (n == COUNT_W'(CLIQUE_EDGES) || n == COUNT_W'(1)) begin
        act_all = 1'b1;
      end else if (n == COUNT_W'(CLIQUE_EDGES - 1)) begin
        act_first = 1'b1;
      end else if (n == COUNT_W'(2)) begin
        act_first = 1'b1;
        f_col     = 1'b1;
        f_skip    = 1'b1;
      end
    end else begin
      if (n == COUNT_W'(0) || n == COUNT_W'(CLIQUE_EDGES - 1)) begin
        act_all = 1'b1;
      end else if (n == COUNT_W'(1)) begin
        act_first = 1'b1;
        f_col     = 1'b1;
      end else if (n == COUNT_W'(CLIQUE_EDGES - 2)) begin
        act_first = 1'b1;
        f_skip    = 1'b1;
      end
    end
  end

  // memory port steering
  always_comb begin
    eg_we     = 1'b0;
    eg_waddr  = e;
    eg_wdata  = eg_rdata;
    eg_re     = 1'b0;
    eg_raddr  = e;
    soe_we    = acc && (req.func == FN_LOAD_SOE);
    soe_waddr = {req.edge_req, req.slot};
    soe_re    = (state == ST_SG_RD);
    soe_raddr = {e, i};
    eos_we    = acc && (req.func == FN_LOAD_EOS) && (req.slot < SLOT_W'(CLIQUE_EDGES));
    eos_waddr = {req.subgraph, req.slot[MEMB_W-1:0]};
    eos_re    = (state == ST_M_RD);
    eos_raddr = {s, j};
    bc_we     = acc && (req.func == FN_INIT_COUNT);
    bc_waddr  = req.subgraph;
    bc_wdata  = req.count;
    bc_re     = (state == ST_SG_D);
    case (state)
      ST_IDLE: begin
        eg_we    = acc && (req.func == FN_INIT_EDGE);
        eg_waddr = req.edge_req;
        eg_wdata = {req.color, req.field_value};
      end
      ST_F_RD, ST_BE_RD, ST_O_RD: begin
        eg_re = 1'b1;
      end
      ST_F_TGL: begin
        eg_we    = 1'b1;
        eg_wdata = {~eg_rdata[FIELD_W], eg_rdata[FIELD_W-1:0]};
      end
      ST_BC_D: begin
        bc_we    = 1'b1;
        bc_waddr = s;
        bc_wdata = n;
      end
      ST_BE_WR: begin
        eg_we    = 1'b1;
        eg_wdata = {eg_rdata[FIELD_W], eg_rdata[FIELD_W-1:0] + d_e};
      end
      ST_M_D: begin
        eg_re    = !(skip_en && eos_rdata == e);
        eg_raddr = eos_rdata;
      end
      ST_M_WR: begin
        eg_we    = m_hit;
        eg_waddr = m;
        eg_wdata = {eg_rdata[FIELD_W], eg_rdata[FIELD_W-1:0] + d_mem};
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          state_next = (req.func == FN_FLIP) ? ST_F_RD : ST_O_RD;
        end
      end
      ST_F_RD:  state_next = ST_F_TGL;
      ST_F_TGL: state_next = ST_SG_RD;
      ST_SG_RD: state_next = ST_SG_D;
      ST_SG_D:  state_next = ST_BC_D;
      ST_BC_D: begin
        if (act_all) begin
          state_next = ST_BE_RD;
        end else if (act_first) begin
          state_next = ST_M_RD;
        end else begin
          state_next = ST_NXT;
        end
      end
      ST_BE_RD: state_next = ST_BE_WR;
      ST_BE_WR: state_next = ST_M_RD;
      ST_M_RD:  state_next = ST_M_D;
      ST_M_D: begin
        if (skip_en && eos_rdata == e) begin
          state_next = last_j ? ST_NXT : ST_M_RD;
        end else begin
          state_next = ST_M_WR;
        end
      end
      ST_M_WR: begin
        if ((m_hit && !mode_all) || last_j) begin
          state_next = ST_NXT;
        end else begin
          state_next = ST_M_RD;
        end
      end
      ST_NXT:  state_next = (i == {SLOT_W{1'b1}}) ? ST_O_RD : ST_SG_RD;
      ST_O_RD: state_next = ST_O_WR;
      ST_O_WR: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_O_WR && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // datapath registers: hold the item, advance the scan counters
  always_ff @(posedge clk) begin
    if (acc) begin
      e <= req.edge_req;
    end
    case (state)
      ST_F_TGL: begin
        blue <= ~eg_rdata[FIELD_W];
        i    <= '0;
      end
      ST_SG_D: s <= soe_rdata;
      ST_BC_D: begin
        mode_all <= act_all;
        want_col <= f_col;
        skip_en  <= f_skip;
        j        <= '0;
      end
      ST_M_D: begin
        m <= eos_rdata;
        if (skip_en && eos_rdata == e) begin
          j <= j + MEMB_W'(1);
        end
      end
      ST_M_WR: j <= j + MEMB_W'(1);
      ST_NXT:  i <= i + SLOT_W'(1);
      ST_O_WR: begin
        if (!rsp_valid || rsp_ready) begin
          rsp.read_color <= eg_rdata[FIELD_W];
          rsp.read_field <= eg_rdata[FIELD_W-1:0];
          rsp.done_res   <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  cfu_ram #(.ADDR_W(EDGE_W), .DATA_W(FIELD_W + 1)) u_edge_ram (
    .clk(clk), .we(eg_we), .waddr(eg_waddr), .wdata(eg_wdata),
    .re(eg_re), .raddr(eg_raddr), .rdata(eg_rdata)
  );

  cfu_ram #(.ADDR_W(EDGE_W + SLOT_W), .DATA_W(SUB_W)) u_soe_ram (
    .clk(clk), .we(soe_we), .waddr(soe_waddr), .wdata(req.subgraph),
    .re(soe_re), .raddr(soe_raddr), .rdata(soe_rdata)
  );

  cfu_ram #(.ADDR_W(SUB_W + MEMB_W), .DATA_W(EDGE_W)) u_eos_ram (
    .clk(clk), .we(eos_we), .waddr(eos_waddr), .wdata(req.edge_req),
    .re(eos_re), .raddr(eos_raddr), .rdata(eos_rdata)
  );

  cfu_ram #(.ADDR_W(SUB_W), .DATA_W(COUNT_W)) u_count_ram (
    .clk(clk), .we(bc_we), .waddr(bc_waddr), .wdata(bc_wdata),
    .re(bc_re), .raddr(soe_rdata), .rdata(bc_rdata)
  );

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the clique field updater: directed and random items, scored against a predictor.
module tb_top
  import cfu_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_EDGES = 256;
  localparam int N_SUBS = 4096;
  localparam int SUBS_PER_EDGE = 128;
  localparam int K = CLIQUE_EDGES;
  localparam int N_RANDOM = 130;
  localparam longint CYCLE_LIMIT = 64'd20000000;
  // Working set kept small so that flips actually hit loaded cliques.
  localparam int POOL_EDGES = 12;
  localparam int FLIP_EDGES = 4;
  localparam int POOL_SUBS = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  clique_field_updater dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Predictor state: a mirror of what the block holds.
  logic                      colour_mir [N_EDGES];
  logic signed [FIELD_W-1:0] field_mir [N_EDGES];
  logic [COUNT_W-1:0]        blue_mir [N_SUBS];
  logic [SUB_W-1:0]          subs_of_edge_mir [N_EDGES][SUBS_PER_EDGE];
  logic [EDGE_W-1:0]         members_mir [N_SUBS][K];

  req_t pending_items[$];
  rsp_t expected_rsp[$];
  int   sender_idle_pct = 23;
  int   receiver_idle_pct = 79;
  bit   sender_paused = 1'b0;
  bit   hold_off_req = 1'b0;
  bit   hold_off_taken = 1'b0;
  int   hold_off_left = 0;
  int   n_errors = 0;
  longint cycle_count = 0;
  bit   all_sent = 1'b0;

  function automatic void nudge(int e, bit up);
    if (e < N_EDGES) field_mir[e] = field_mir[e] + (up ? 16'sd1 : -16'sd1);
  endfunction

  // Adjust the first member with the given colour, optionally skipping one edge.
  function automatic void nudge_first(int s, bit col, int skip, bit up);
    int e;
    for (int j = 0; j < K; j++) begin
      e = members_mir[s][j];
      if (e != skip && colour_mir[e] == col) begin
        nudge(e, up);
        return;
      end
    end
  endfunction

  function automatic void nudge_members(int s, bit up);
    for (int j = 0; j < K; j++) nudge(members_mir[s][j], up);
  endfunction

  function automatic void apply_flip(int e);
    int s;
    bit blue;
    logic [COUNT_W-1:0] n;
    colour_mir[e] = ~colour_mir[e];
    blue = colour_mir[e];
    for (int i = 0; i < SUBS_PER_EDGE; i++) begin
      s = subs_of_edge_mir[e][i];
      n = blue ? blue_mir[s] + 4'd1 : blue_mir[s] - 4'd1;
      blue_mir[s] = n;
      if (blue) begin
        if (n == K || n == 1) begin
          nudge(e, 1'b1); nudge_members(s, 1'b0);
        end else if (n == K - 1) nudge_first(s, 1'b0, -1, 1'b0);
        else if (n == 2) nudge_first(s, 1'b1, e, 1'b0);
      end else begin
        if (n == 0 || n == K - 1) begin
          nudge(e, 1'b0); nudge_members(s, 1'b1);
        end else if (n == 1) nudge_first(s, 1'b1, -1, 1'b1);
        else if (n == K - 2) nudge_first(s, 1'b0, e, 1'b1);
      end
    end
  endfunction

  function automatic rsp_t predict_item(req_t it);
    rsp_t r;
    case (it.func)
      FN_LOAD_SOE: if (it.slot < SUBS_PER_EDGE) subs_of_edge_mir[it.edge_req][it.slot] = it.subgraph;
      FN_LOAD_EOS: if (it.slot < K) members_mir[it.subgraph][it.slot] = it.edge_req;
      FN_INIT_EDGE: begin
        colour_mir[it.edge_req] = it.color;
        field_mir[it.edge_req] = it.field_value;
      end
      FN_INIT_COUNT: blue_mir[it.subgraph] = it.count;
      FN_FLIP: apply_flip(it.edge_req);
      default: ;
    endcase
    r.read_color = colour_mir[it.edge_req];
    r.read_field = field_mir[it.edge_req];
    r.done_res = 1'b1;
    return r;
  endfunction

  function automatic req_t make_item(func_t f, int e, int sl, int s, int fv, int c, int cnt);
    req_t it;
    it.func = f;
    it.edge_req = e[EDGE_W-1:0];
    it.slot = sl[SLOT_W-1:0];
    it.subgraph = s[SUB_W-1:0];
    it.field_value = fv[FIELD_W-1:0];
    it.color = c[0];
    it.count = cnt[COUNT_W-1:0];
    return it;
  endfunction

  task automatic push(req_t it);
    pending_items.push_back(it);
  endtask

  // Initialise every pool edge, load full incidence rows only for the edges
  // that get flipped, and fill counts and members of every pool subgraph with
  // pool edges, so that no item ever reads an unwritten entry.
  task automatic bring_up_pool();
    for (int e = 0; e < POOL_EDGES; e++) begin
      push(make_item(FN_INIT_EDGE, e, 0, 0, $urandom, $urandom_range(0, 1), 0));
    end
    for (int e = 0; e < FLIP_EDGES; e++) begin
      for (int i = 0; i < SUBS_PER_EDGE; i++)
        push(make_item(FN_LOAD_SOE, e, i, $urandom_range(0, POOL_SUBS - 1), 0, 0, 0));
    end
    for (int s = 0; s < POOL_SUBS; s++) begin
      push(make_item(FN_INIT_COUNT, 0, 0, s, 0, 0, $urandom_range(0, 15)));
      for (int j = 0; j < K; j++)
        push(make_item(FN_LOAD_EOS, $urandom_range(0, POOL_EDGES - 1), j, s, 0, 0, 0));
    end
  endtask

  function automatic req_t random_item();
    int r;
    int e;
    int fe;
    int s;
    r = $urandom_range(0, 99);
    e = $urandom_range(0, POOL_EDGES - 1);
    fe = $urandom_range(0, FLIP_EDGES - 1);
    s = $urandom_range(0, POOL_SUBS - 1);
    if (r < 40) return make_item(FN_FLIP, fe, $urandom, $urandom, $urandom, $urandom, $urandom);
    if (r < 55) return make_item(FN_READ, e, $urandom, $urandom, $urandom, $urandom, $urandom);
    if (r < 65) return make_item(FN_INIT_EDGE, e, $urandom, $urandom, $urandom,
                                 $urandom, $urandom);
    if (r < 75) return make_item(FN_INIT_COUNT, $urandom_range(0, POOL_EDGES - 1), $urandom,
                                 s, $urandom, $urandom, $urandom);
    if (r < 83) return make_item(FN_LOAD_SOE, fe, $urandom_range(0, SUBS_PER_EDGE - 1),
                                 s, $urandom, $urandom, $urandom);
    if (r < 91) return make_item(FN_LOAD_EOS, e, $urandom_range(0, K - 1), s,
                                 $urandom, $urandom, $urandom);
    // Unused codes and out-of-row slots: no state change, pool edge reported.
    if (r < 95) return make_item(func_t'($urandom_range(6, 7)), e, $urandom, $urandom,
                                 $urandom, $urandom, $urandom);
    if (r < 98) return make_item(FN_LOAD_EOS, e, $urandom_range(K, 127), s,
                                 $urandom, $urandom, $urandom);
    return make_item(FN_LOAD_SOE, fe, 0, s, 0, 0, 0);
  endfunction

  // Driver: offer the queue head, hold it until accepted.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_ready) begin
      // hold
    end else if (pending_items.size() > 0 && !sender_paused &&
                 $urandom_range(0, 99) >= sender_idle_pct) begin
      req <= pending_items.pop_front();
      req_valid <= 1'b1;
    end else begin
      req_valid <= 1'b0;
    end
  end

  // Predict at acceptance so results line up with the order of beats.
  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) expected_rsp.push_back(predict_item(req));
  end

  // Receiver: random stalls plus one long hold-off, counted here.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_off_req && !hold_off_taken) begin
      hold_off_taken <= 1'b1;
      hold_off_left <= 6000;
      rsp_ready <= 1'b0;
    end else if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // Monitor: compare each response beat with the oldest expectation.
  always @(posedge clk) begin
    rsp_t exp_r;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected response beat: %p", rsp);
      end else begin
        exp_r = expected_rsp.pop_front();
        if (rsp.read_color !== exp_r.read_color || rsp.read_field !== exp_r.read_field ||
            rsp.done_res !== exp_r.done_res) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: expected colour %0b field %0d done %0b, got %0b %0d %0b",
                     exp_r.read_color, exp_r.read_field, exp_r.done_res,
                     rsp.read_color, rsp.read_field, rsp.done_res);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic drain();
    wait (pending_items.size() == 0);
    while (req_valid || expected_rsp.size() > 0) @(posedge clk);
  endtask

  initial begin
    for (int e = 0; e < N_EDGES; e++) begin
      colour_mir[e] = 1'b0; field_mir[e] = '0;
      for (int i = 0; i < SUBS_PER_EDGE; i++) subs_of_edge_mir[e][i] = '0;
    end
    for (int s = 0; s < N_SUBS; s++) begin
      blue_mir[s] = '0;
      for (int j = 0; j < K; j++) members_mir[s][j] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    bring_up_pool();
    // Directed: field extremes, wrap, every code but FN_LOAD_SOE, clique completion and teardown.
    push(make_item(FN_INIT_EDGE, 0, 0, 0, 32767, 1, 0));
    push(make_item(FN_INIT_EDGE, 1, 127, 4095, -32768, 0, 15));
    push(make_item(FN_READ, 0, 127, 4095, -1, 1, 15));
    push(make_item(FN_FLIP, 0, 0, 0, 0, 0, 0));
    push(make_item(FN_FLIP, 1, 0, 0, 0, 0, 0));
    push(make_item(FN_INIT_COUNT, 0, 0, 4095, 0, 0, 15));
    push(make_item(FN_INIT_COUNT, 0, 0, 0, 0, 0, K - 1));
    push(make_item(FN_INIT_EDGE, 2, 0, 0, 0, 0, 0));
    push(make_item(FN_FLIP, 2, 0, 0, 0, 0, 0));
    push(make_item(FN_FLIP, 2, 0, 0, 0, 0, 0));
    push(make_item(FN_INIT_COUNT, 0, 0, 1, 0, 0, 15));
    push(make_item(FN_FLIP, 3, 0, 0, 0, 0, 0));
    push(make_item(FN_FLIP, 3, 0, 0, 0, 0, 0));
    push(make_item(func_t'(3'd7), 4, 127, 4095, 0, 1, 15));
    push(make_item(func_t'(3'd6), 5, 0, 0, 0, 0, 0));
    push(make_item(FN_INIT_EDGE, 255, 0, 0, -1, 1, 0));
    push(make_item(FN_LOAD_EOS, 255, 127, 4095, 0, 0, 0));
    push(make_item(FN_READ, 255, 0, 0, 0, 0, 0));
    drain();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) begin
        drain();
        sender_idle_pct = 79; receiver_idle_pct = 23;
        hold_off_req = 1'b1;  // long receiver stall while items keep coming
      end
      if (i == 2 * N_RANDOM / 3) begin
        drain();
        sender_idle_pct = 0; receiver_idle_pct = 0;
      end
      push(random_item());
    end
    drain();
    // Sender pause once everything is back, then a short tail.
    sender_paused = 1'b1;
    repeat (20) @(posedge clk);
    sender_paused = 1'b0;
    for (int i = 0; i < 20; i++) push(random_item());
    drain();
    repeat (3000) @(posedge clk);
    if (n_errors == 0 && expected_rsp.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
sv/cfu_pkg.sv
sv/cfu_ram.sv
sv/clique_field_updater.sv
tb/tb_top.sv
